### hw/rtl/dmir_pkg.sv
// ----------------------------------------------------------------------------
// dmir_pkg
// shared widths and register indexes for the icon pixel recolour pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package dmir_pkg;

	localparam int NUM_W = 16;
	localparam int DEN_W = 8;
	localparam int RCP_W = 17;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_LUM_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] REG_TARGET_LUM    = 2'd1;

	localparam logic [8:0] LUM_THRESHOLD_RST = 9'd160;
	localparam logic [7:0] TARGET_LUM_RST    = 8'd230;

	typedef struct packed {
		logic        valid;
		logic [31:0] px;
	} side_t;

endpackage

`default_nettype wire

### hw/rtl/dmir_div.sv
// ----------------------------------------------------------------------------
// dmir_div
// two-stage 16 by 8 bit divider: reciprocal multiply, then one correction step
// ----------------------------------------------------------------------------
`default_nettype none

module dmir_div
	import dmir_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [NUM_W-1:0] quo
);

	logic [RCP_W-1:0] rcp_tab [2**DEN_W];

	assign rcp_tab[0] = '0;
	for (genvar d = 1; d < 2**DEN_W; d++) begin : g_rcp
		localparam logic [RCP_W-1:0] RCP = RCP_W'((2**NUM_W) / d);
		assign rcp_tab[d] = RCP;
	end

	logic [NUM_W+RCP_W-1:0] prod_s1;
	logic [NUM_W-1:0]       num_s1;
	logic [DEN_W-1:0]       den_s1;
	logic [NUM_W-1:0]       q0_s2;
	logic [NUM_W+DEN_W-1:0] qd_s2;
	logic [NUM_W-1:0]       num_s2;
	logic [DEN_W-1:0]       den_s2;
	logic [NUM_W-1:0]       q0;
	logic [NUM_W:0]         rem;

	assign q0 = prod_s1[NUM_W +: NUM_W];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (NUM_W+RCP_W)'(num) * (NUM_W+RCP_W)'(rcp_tab[den]);
			num_s1  <= num;
			den_s1  <= den;
			q0_s2   <= q0;
			qd_s2   <= (NUM_W+DEN_W)'(q0) * (NUM_W+DEN_W)'(den_s1);
			num_s2  <= num_s1;
			den_s2  <= den_s1;
		end
	end

	// estimate is exact or one short
	assign rem = {1'b0, num_s2} - qd_s2[NUM_W:0];
	assign quo = q0_s2 + NUM_W'(rem >= {{(NUM_W+1-DEN_W){1'b0}}, den_s2});

endmodule

`default_nettype wire

### hw/rtl/dark_mode_icon_pixel_recolor_unit.sv
// ----------------------------------------------------------------------------
// dark_mode_icon_pixel_recolor_unit
// brightens dark premultiplied argb pixels towards a target luminance
// pipeline: an input request is registered through s1 to s8, then out_valid
// throughput: one pixel per cycle; a stall at the output holds every stage
// reset: pipeline empty, lum_threshold 160, target_lum 230
// ----------------------------------------------------------------------------
`default_nettype none

module dark_mode_icon_pixel_recolor_unit
	import dmir_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [31:0]      pixel_in,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [31:0]      pixel_out,
	output logic                  recolored,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [8:0]       cfg_data
);

	logic [8:0] lum_threshold_q;
	logic [7:0] target_lum_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lum_threshold_q <= LUM_THRESHOLD_RST;
			target_lum_q    <= TARGET_LUM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LUM_THRESHOLD: lum_threshold_q <= cfg_data;
				REG_TARGET_LUM:    target_lum_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	side_t s1, s2, s3, s4, s5, s6, s7, s8;
	logic [NUM_W-1:0] n_s1 [3];
	logic [NUM_W-1:0] qu   [3];
	logic [7:0]       u_s4 [3];
	logic [15:0]      lsum_s4;
	logic [NUM_W-1:0] n_s5 [3];
	logic [DEN_W-1:0] lden_s5;
	logic             hit_s5, hit_s6, hit_s7, hit_s8;
	logic             zero_s5, zero_s6, zero_s7;
	logic [NUM_W-1:0] qs   [3];
	logic [15:0]      pm_s8 [3];

	logic [7:0]       uc   [3];
	logic [7:0]       sc   [3];
	logic [7:0]       pq   [3];
	logic [7:0]       lum;

	assign lum = lsum_s4[15:8];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		dmir_div u_unpm (
			.clk (clk),
			.en  (adv),
			.num (n_s1[c]),
			.den (s1.px[31:24]),
			.quo (qu[c])
		);
		dmir_div u_scale (
			.clk (clk),
			.en  (adv),
			.num (n_s5[c]),
			.den (lden_s5),
			.quo (qs[c])
		);
		assign uc[c] = (qu[c] > 16'd255) ? 8'd255 : qu[c][7:0];
		assign sc[c] = zero_s7 ? target_lum_q :
			((qs[c] > 16'd255) ? 8'd255 : qs[c][7:0]);
		// divide by 255, exact below 2^16
		assign pq[c] = 8'((33'(pm_s8[c]) * 33'd32897) >> 23);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1        <= '0;
			s2        <= '0;
			s3        <= '0;
			s4        <= '0;
			s5        <= '0;
			s6        <= '0;
			s7        <= '0;
			s8        <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			s1        <= '{in_valid, pixel_in};
			s2        <= s1;
			s3        <= s2;
			s4        <= s3;
			s5        <= s4;
			s6        <= s5;
			s7        <= s6;
			s8        <= s7;
			out_valid <= s8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// un-premultiply numerators
			for (int c = 0; c < 3; c++) begin
				n_s1[c] <= {pixel_in[8*c +: 8], 8'd0} - 16'(pixel_in[8*c +: 8])
					+ 16'(pixel_in[31:25]);
			end
			// clamp and luminance sum
			for (int c = 0; c < 3; c++) begin
				u_s4[c] <= uc[c];
			end
			lsum_s4 <= 16'(uc[0]) * 16'd54 + 16'(uc[1]) * 16'd183
				+ 16'(uc[2]) * 16'd19;
			// threshold test and scale numerators
			hit_s5  <= (s4.px[31:24] != 8'd0) && ({1'b0, lum} < lum_threshold_q);
			zero_s5 <= (lum == 8'd0);
			lden_s5 <= (lum == 8'd0) ? 8'd1 : lum;
			for (int c = 0; c < 3; c++) begin
				n_s5[c] <= 16'(u_s4[c]) * 16'(target_lum_q);
			end
			hit_s6  <= hit_s5;
			zero_s6 <= zero_s5;
			hit_s7  <= hit_s6;
			zero_s7 <= zero_s6;
			// re-premultiply
			hit_s8 <= hit_s7;
			for (int c = 0; c < 3; c++) begin
				pm_s8[c] <= 16'(sc[c]) * 16'(s7.px[31:24]) + 16'd127;
			end
			pixel_out <= hit_s8 ? {s8.px[31:24], pq[2], pq[1], pq[0]} : s8.px;
			recolored <= hit_s8;
		end
	end

	a_hit_alpha : assert property (@(posedge clk) disable iff (!arst_n)
		s8.valid && hit_s8 |-> s8.px[31:24] != 8'd0)
		else $error("recolour flagged on zero alpha");

	a_out_alpha : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recolored |-> pixel_out[31:24] != 8'd0)
		else $error("recoloured pixel lost its alpha");

	a_flow : assert property (@(posedge clk) disable iff (!arst_n)
		s8.valid && adv |=> out_valid)
		else $error("request dropped at output stage");

endmodule

`default_nettype wire
